>>> hw/rtl/lpht_pkg.sv
// Package for the linear probing hash table: sizes, opcodes, status codes
// and the command and status structs between controller and datapath.
// No dependencies.
package lpht_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int KEY_WORDS   = 6;
    localparam int HASH_ROT    = 17;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 13;
    localparam int DIV_BITS    = 4;
    localparam int DIV_STEPS   = 64 / DIV_BITS;
    localparam int DIVC_W      = $clog2(DIV_STEPS);

    localparam logic [2:0] OP_OVERWRITE = 3'd0;
    localparam logic [2:0] OP_SHORTER   = 3'd1;
    localparam logic [2:0] OP_IF_NEW    = 3'd2;
    localparam logic [2:0] OP_LOOKUP    = 3'd3;
    localparam logic [2:0] OP_CLEAR     = 3'd4;

    localparam logic [1:0] ST_DONE        = 2'd0;
    localparam logic [1:0] ST_NOT_APPLIED = 2'd1;
    localparam logic [1:0] ST_FULL        = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND   = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [KEY_WORDS*64-1:0] key;
        logic [31:0]      handle;
        logic [7:0]       len;
    } slot_entry_t;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       probe_init;
        logic       probe_rd;
        logic       probe_adv;
        logic       clr_step;
        logic       wr_entry;
        logic       cnt_inc;
        logic       cnt_clr;
        logic       out_load;
        logic [1:0] res_status;
        logic       res_found;
        logic       res_slot0;
    } lpht_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       div_last;
        logic       hit_empty;
        logic       hit_match;
        logic       len_le;
        logic       tried_all;
        logic       clr_last;
    } lpht_stat_t;

endpackage

>>> hw/rtl/lpht_if.sv
// Handshake channels of the hash table: request items in, result items out.
// Depends on nothing.
interface lpht_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [63:0] key_face_0;
    logic [63:0] key_face_1;
    logic [63:0] key_face_2;
    logic [63:0] key_face_3;
    logic [63:0] key_face_4;
    logic [63:0] key_face_5;
    logic [31:0] value_handle;
    logic [7:0]  move_length;

    modport source (output valid, opcode, key_face_0, key_face_1, key_face_2, key_face_3,
                    key_face_4, key_face_5, value_handle, move_length, input ready);
    modport sink   (input valid, opcode, key_face_0, key_face_1, key_face_2, key_face_3,
                    key_face_4, key_face_5, value_handle, move_length, output ready);
endinterface

interface lpht_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] found_handle;
    logic [7:0]  found_length;
    logic [11:0] slot_index;
    logic [12:0] entry_count;

    modport source (output valid, status, found_handle, found_length, slot_index,
                    entry_count, input ready);
    modport sink   (input valid, status, found_handle, found_length, slot_index,
                    entry_count, output ready);
endinterface

>>> hw/rtl/lpht_dp.sv
// Datapath of the hash table: hash, home slot divider, slot memory,
// probe index, entry count and result registers. Uses lpht_pkg.
module lpht_dp
    import lpht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_wdata,
    input  logic [2:0]        opcode,
    input  logic [63:0]       key_face_0,
    input  logic [63:0]       key_face_1,
    input  logic [63:0]       key_face_2,
    input  logic [63:0]       key_face_3,
    input  logic [63:0]       key_face_4,
    input  logic [63:0]       key_face_5,
    input  logic [31:0]       value_handle,
    input  logic [7:0]        move_length,
    input  lpht_cmd_t         cmd,
    output lpht_stat_t        stat,
    output logic [1:0]        status,
    output logic [31:0]       found_handle,
    output logic [7:0]        found_length,
    output logic [11:0]       slot_index,
    output logic [12:0]       entry_count
);

    slot_entry_t mem [TABLE_DEPTH];
    slot_entry_t rd_reg;

    logic [CNT_W-1:0]        slots_reg;
    logic [CNT_W-1:0]        n_act;
    logic [2:0]              op_reg;
    logic [KEY_WORDS*64-1:0] key_reg;
    logic [31:0]             handle_reg;
    logic [7:0]              len_reg;
    logic [63:0]             quo_reg;
    logic [CNT_W-1:0]        rem_reg, rem_next;
    logic [DIVC_W-1:0]       divc_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [CNT_W-1:0]        tries_reg;
    logic [IDX_W-1:0]        clr_reg;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [KEY_WORDS*64-1:0] key_in;
    logic [63:0]             hash;
    logic [CNT_W:0]          part;
    logic [CNT_W-1:0]        idx_inc;

    assign key_in = {key_face_5, key_face_4, key_face_3, key_face_2, key_face_1, key_face_0};

    always_comb
    begin
        if (slots_reg == '0)
            n_act = CNT_W'(1);
        else if (slots_reg > CNT_W'(TABLE_DEPTH))
            n_act = CNT_W'(TABLE_DEPTH);
        else
            n_act = slots_reg;
    end

    // fold and rotate each key word; rotation is wiring only
    always_comb
    begin
        hash = '0;
        for (int i = 0; i < KEY_WORDS; i++)
        begin
            hash = hash ^ key_in[i*64 +: 64];
            hash = {hash[63-HASH_ROT:0], hash[63:64-HASH_ROT]};
        end
    end

    // restoring remainder, DIV_BITS quotient bits per step
    always_comb
    begin
        rem_next = rem_reg;
        part     = '0;
        for (int j = 0; j < DIV_BITS; j++)
        begin
            part = {rem_next, quo_reg[63-j]};
            if (part >= {1'b0, n_act})
                part = part - {1'b0, n_act};
            rem_next = part[CNT_W-1:0];
        end
    end

    assign idx_inc = {1'b0, idx_reg} + CNT_W'(1);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
            cnt_next = '0;
        else if (cmd.cnt_inc)
            cnt_next = cnt_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= CNT_W'(TABLE_DEPTH);
            cnt_reg   <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                slots_reg <= cfg_wdata;
            cnt_reg <= cnt_next;
            if (cmd.clr_step)
                clr_reg <= clr_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= opcode;
            key_reg    <= key_in;
            handle_reg <= value_handle;
            len_reg    <= move_length;
            quo_reg    <= hash;
            rem_reg    <= '0;
            divc_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg  <= quo_reg << DIV_BITS;
            rem_reg  <= rem_next;
            divc_reg <= divc_reg + DIVC_W'(1);
        end
        if (cmd.probe_init)
        begin
            idx_reg   <= rem_reg[IDX_W-1:0];
            tries_reg <= '0;
        end
        else
        begin
            if (cmd.probe_rd)
                tries_reg <= tries_reg + CNT_W'(1);
            if (cmd.probe_adv)
                idx_reg <= (idx_inc == n_act) ? '0 : idx_inc[IDX_W-1:0];
        end
        if (cmd.out_load)
        begin
            status       <= cmd.res_status;
            found_handle <= cmd.res_found ? rd_reg.handle : 32'd0;
            found_length <= cmd.res_found ? rd_reg.len : 8'd0;
            slot_index   <= cmd.res_slot0 ? 12'd0 : 12'(idx_reg);
            entry_count  <= cnt_next;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            mem[clr_reg] <= '{valid: 1'b0, key: key_reg, handle: handle_reg, len: len_reg};
        else if (cmd.wr_entry)
            mem[idx_reg] <= '{valid: 1'b1, key: key_reg, handle: handle_reg, len: len_reg};
        if (cmd.probe_rd)
            rd_reg <= mem[idx_reg];
    end

    assign stat.op        = op_reg;
    assign stat.div_last  = (divc_reg == DIVC_W'(DIV_STEPS - 1));
    assign stat.hit_empty = !rd_reg.valid;
    assign stat.hit_match = rd_reg.valid && (rd_reg.key == key_reg);
    assign stat.len_le    = (rd_reg.len <= len_reg);
    assign stat.tried_all = (tries_reg == n_act);
    assign stat.clr_last  = (clr_reg == IDX_W'(TABLE_DEPTH - 1));

endmodule

>>> hw/rtl/lpht_ctrl.sv
// Controller of the hash table: sequences hash, divide, probe, clear and
// result hand-off. Uses lpht_pkg.
module lpht_ctrl
    import lpht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] opcode,
    output logic       out_valid,
    input  logic       out_ready,
    input  lpht_stat_t stat,
    output lpht_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_PINIT = 8'b0000_1000,
        S_PRD   = 8'b0001_0000,
        S_PCMP  = 8'b0010_0000,
        S_CLR   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   is_write;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign is_write = (stat.op == OP_OVERWRITE) || (stat.op == OP_SHORTER) ||
                      (stat.op == OP_IF_NEW);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (opcode == OP_CLEAR)
                        state_next = S_CLR;
                    else if (opcode <= OP_LOOKUP)
                        state_next = S_DIV;
                    else
                        state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_PINIT;
            end
            S_PINIT:
            begin
                cmd.probe_init = 1'b1;
                state_next     = S_PRD;
            end
            S_PRD:
            begin
                cmd.probe_rd = 1'b1;
                state_next   = S_PCMP;
            end
            S_PCMP:
            begin
                if (stat.hit_empty || stat.hit_match || stat.tried_all)
                begin
                    // hold here until the result register is free
                    if (out_free)
                    begin
                        cmd.out_load = 1'b1;
                        state_next   = S_IDLE;
                        if (stat.hit_empty)
                        begin
                            if (is_write)
                            begin
                                cmd.wr_entry   = 1'b1;
                                cmd.cnt_inc    = 1'b1;
                                cmd.res_status = ST_DONE;
                            end
                            else
                                cmd.res_status = ST_NOT_FOUND;
                        end
                        else if (stat.hit_match)
                        begin
                            if (stat.op == OP_LOOKUP)
                            begin
                                cmd.res_found  = 1'b1;
                                cmd.res_status = ST_DONE;
                            end
                            else if (stat.op == OP_IF_NEW ||
                                     (stat.op == OP_SHORTER && stat.len_le))
                                cmd.res_status = ST_NOT_APPLIED;
                            else
                            begin
                                cmd.wr_entry   = 1'b1;
                                cmd.res_status = ST_DONE;
                            end
                        end
                        else
                        begin
                            cmd.res_slot0  = 1'b1;
                            cmd.res_status = is_write ? ST_FULL : ST_NOT_FOUND;
                        end
                    end
                end
                else
                begin
                    cmd.probe_adv = 1'b1;
                    state_next    = S_PRD;
                end
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.res_slot0 = 1'b1;
                    if (stat.op == OP_CLEAR)
                    begin
                        cmd.cnt_clr    = 1'b1;
                        cmd.res_status = ST_DONE;
                    end
                    else
                        cmd.res_status = ST_NOT_APPLIED;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_INIT;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hw/rtl/linear_probe_hash_table.sv
// Top level of the linear probing hash table: controller plus datapath.
// Uses lpht_pkg, lpht_if, lpht_ctrl and lpht_dp.
//
// Usage
//   in_ch carries one request item (opcode, six key words, handle, length);
//   it is taken when valid and ready are both high. out_ch returns exactly
//   one result item per request, in order. cfg_we/cfg_wdata write the active
//   slot count; write it only while the block is idle.
// Sequence
//   One item at a time. A lookup or update is accepted, then the home slot
//   remainder is found (four quotient bits a cycle), the probe is set up,
//   and each probed slot gets a registered memory read, then a key compare.
//   A clear sweeps all 4096 slots, one a cycle, then reports.
//   Unknown opcodes go straight to the report state and report not applied.
// Reset
//   After reset a sweep over all 4096 slots clears every valid bit; ready stays
//   low until it ends. Configuration writes are taken during the sweep.
// Stalls
//   The result sits in an output register; while it waits, the next item is
//   accepted and worked on, and the block holds at its last step until the
//   register frees up.
module linear_probe_hash_table
    import lpht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [12:0]       cfg_wdata,
    lpht_in_if.sink           in_ch,
    lpht_out_if.source        out_ch
);

    lpht_cmd_t  cmd;
    lpht_stat_t stat;

    // sequence the work
    lpht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .opcode    (in_ch.opcode),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // hold the table, the hash and the result
    lpht_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .opcode       (in_ch.opcode),
        .key_face_0   (in_ch.key_face_0),
        .key_face_1   (in_ch.key_face_1),
        .key_face_2   (in_ch.key_face_2),
        .key_face_3   (in_ch.key_face_3),
        .key_face_4   (in_ch.key_face_4),
        .key_face_5   (in_ch.key_face_5),
        .value_handle (in_ch.value_handle),
        .move_length  (in_ch.move_length),
        .cmd          (cmd),
        .stat         (stat),
        .status       (out_ch.status),
        .found_handle (out_ch.found_handle),
        .found_length (out_ch.found_length),
        .slot_index   (out_ch.slot_index),
        .entry_count  (out_ch.entry_count)
    );

    // busy for the whole of an item once taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("request taken while busy");

    // count never exceeds the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.entry_count <= 13'(TABLE_DEPTH)))
        else $error("entry count out of range");

    // a full table reports slot zero
    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status == ST_FULL) |-> (out_ch.slot_index == 12'd0))
        else $error("full status with non-zero slot");

    // stored data only leaves on a successful lookup
    a_no_leak: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status != ST_DONE) |->
        (out_ch.found_handle == 32'd0 && out_ch.found_length == 8'd0))
        else $error("handle reported without a hit");

endmodule

>>> dv/tb_linear_probe_hash_table.sv
// Self-checking testbench for linear_probe_hash_table: directed table, then random
// phases under several slot counts and idling mixes, checked against a local predictor.
// Depends on lpht_pkg, lpht_if and the RTL of the block.
`timescale 1ns / 100ps

module tb_linear_probe_hash_table;
    import lpht_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int POOL_KEYS   = 14;   // twelve random keys, then all zeros, then all ones

    typedef struct {
        logic [2:0]  op;
        logic [63:0] key [KEY_WORDS];
        logic [31:0] handle;
        logic [7:0]  len;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] handle;
        logic [7:0]  len;
        logic [11:0] slot;
        logic [12:0] count;
    } outcome_t;

    typedef struct packed {
        logic        chk;
        logic [1:0]  status;
        logic [12:0] count;
    } pinned_t;

    typedef struct {
        logic        is_cfg;
        logic [12:0] cfg;
        logic [2:0]  op;
        int          key_sel;
        logic [31:0] handle;
        logic [7:0]  len;
        logic        chk;
        logic [1:0]  status;
        logic [12:0] count;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [12:0] cfg_wdata;

    lpht_in_if  in_ch ();
    lpht_out_if out_ch ();

    linear_probe_hash_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Shadow of the table as the block should hold it
    logic [12:0] tbl_slots_reg;
    logic        tbl_valid  [TABLE_DEPTH];
    logic [63:0] tbl_key    [TABLE_DEPTH][KEY_WORDS];
    logic [31:0] tbl_handle [TABLE_DEPTH];
    logic [7:0]  tbl_len    [TABLE_DEPTH];
    logic [12:0] tbl_count;

    outcome_t    outcome_q [$];
    pinned_t     pinned_q  [$];
    stim_row_t   stim_rows [$];
    logic [63:0] key_pool  [POOL_KEYS][KEY_WORDS];

    pinned_t     cur_pin;
    int          idle_in;
    int          idle_out;
    int          errors;
    int          cycles;
    int          n_results;
    int          n_status [4];

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Hash: XOR each word in, rotate left by the hash constant
    function automatic logic [63:0] key_hash(input logic [63:0] k [KEY_WORDS]);
        logic [63:0] h;
        h = '0;
        for (int i = 0; i < KEY_WORDS; i++)
        begin
            h = h ^ k[i];
            h = {h[63-HASH_ROT:0], h[63:64-HASH_ROT]};
        end
        return h;
    endfunction

    // Work out the result of one request and advance the shadow table
    function automatic outcome_t table_apply(input request_t rq);
        outcome_t    o;
        int          n;
        int          idx;
        int          where;
        bit          hit_empty;
        bit          hit_match;
        bit          same;
        n = (tbl_slots_reg == 0) ? 1 : (tbl_slots_reg > TABLE_DEPTH) ? TABLE_DEPTH
                                                                      : tbl_slots_reg;
        o = '0;
        hit_empty = 0;
        hit_match = 0;
        where = 0;
        if (rq.op <= OP_LOOKUP)
        begin
            idx = int'(key_hash(rq.key) % 64'(n));
            for (int t = 0; t < n && !hit_empty && !hit_match; t++)
            begin
                if (!tbl_valid[idx])
                begin
                    hit_empty = 1;
                    where = idx;
                end
                else
                begin
                    same = 1;
                    for (int i = 0; i < KEY_WORDS; i++)
                        if (tbl_key[idx][i] != rq.key[i])
                            same = 0;
                    if (same)
                    begin
                        hit_match = 1;
                        where = idx;
                    end
                    else
                        idx = (idx + 1 >= n) ? 0 : idx + 1;
                end
            end
        end
        if (rq.op <= OP_IF_NEW)
        begin
            o.slot = where[11:0];
            if (!hit_empty && !hit_match)
                o.status = ST_FULL;
            else if (hit_empty)
            begin
                for (int i = 0; i < KEY_WORDS; i++)
                    tbl_key[where][i] = rq.key[i];
                tbl_handle[where] = rq.handle;
                tbl_len[where] = rq.len;
                tbl_valid[where] = 1'b1;
                tbl_count = tbl_count + 13'd1;
            end
            else if (rq.op == OP_IF_NEW || (rq.op == OP_SHORTER && tbl_len[where] <= rq.len))
                o.status = ST_NOT_APPLIED;
            else
            begin
                tbl_handle[where] = rq.handle;
                tbl_len[where] = rq.len;
            end
        end
        else if (rq.op == OP_LOOKUP)
        begin
            o.slot = where[11:0];
            if (hit_match)
            begin
                o.handle = tbl_handle[where];
                o.len = tbl_len[where];
            end
            else
                o.status = ST_NOT_FOUND;
        end
        else if (rq.op == OP_CLEAR)
        begin
            for (int s = 0; s < TABLE_DEPTH; s++)
                tbl_valid[s] = 1'b0;
            tbl_count = '0;
        end
        else
            o.status = ST_NOT_APPLIED;
        o.count = tbl_count;
        return o;
    endfunction

    // Accepted request: predict at the same edge
    always @(posedge clk)
    begin
        request_t rq;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            rq.op = in_ch.opcode;
            rq.key[0] = in_ch.key_face_0;
            rq.key[1] = in_ch.key_face_1;
            rq.key[2] = in_ch.key_face_2;
            rq.key[3] = in_ch.key_face_3;
            rq.key[4] = in_ch.key_face_4;
            rq.key[5] = in_ch.key_face_5;
            rq.handle = in_ch.value_handle;
            rq.len = in_ch.move_length;
            outcome_q.push_back(table_apply(rq));
            pinned_q.push_back(cur_pin);
        end
    end

    // Accepted result: compare field by field with the oldest expectation
    always @(posedge clk)
    begin
        outcome_t exp_o;
        pinned_t  pin;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (outcome_q.size() == 0)
            begin
                $display("%0t: result with nothing expected: status %0d slot %0d", $time,
                         out_ch.status, out_ch.slot_index);
                errors++;
            end
            else
            begin
                exp_o = outcome_q.pop_front();
                pin = pinned_q.pop_front();
                n_results++;
                n_status[out_ch.status]++;
                if (pin.chk && (pin.status !== exp_o.status || pin.count !== exp_o.count))
                begin
                    $display("%0t: table row disagrees with predictor: exp %0d/%0d pred %0d/%0d",
                             $time, pin.status, pin.count, exp_o.status, exp_o.count);
                    errors++;
                end
                if (out_ch.status !== exp_o.status)
                begin
                    $display("%0t: status exp %0d act %0d", $time, exp_o.status, out_ch.status);
                    errors++;
                end
                if (out_ch.found_handle !== exp_o.handle)
                begin
                    $display("%0t: found_handle exp %h act %h", $time, exp_o.handle,
                             out_ch.found_handle);
                    errors++;
                end
                if (out_ch.found_length !== exp_o.len)
                begin
                    $display("%0t: found_length exp %0d act %0d", $time, exp_o.len,
                             out_ch.found_length);
                    errors++;
                end
                if (out_ch.slot_index !== exp_o.slot)
                begin
                    $display("%0t: slot_index exp %0d act %0d", $time, exp_o.slot,
                             out_ch.slot_index);
                    errors++;
                end
                if (out_ch.entry_count !== exp_o.count)
                begin
                    $display("%0t: entry_count exp %0d act %0d", $time, exp_o.count,
                             out_ch.entry_count);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls, redrawn each falling edge
    always @(negedge clk)
        out_ch.ready = ($urandom_range(99) >= idle_out);

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one item, idling first at the sender's rate; return once it is taken
    task automatic send_item(input request_t rq, input pinned_t pin);
        @(negedge clk);
        while ($urandom_range(99) < idle_in)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.opcode = rq.op;
        in_ch.key_face_0 = rq.key[0];
        in_ch.key_face_1 = rq.key[1];
        in_ch.key_face_2 = rq.key[2];
        in_ch.key_face_3 = rq.key[3];
        in_ch.key_face_4 = rq.key[4];
        in_ch.key_face_5 = rq.key[5];
        in_ch.value_handle = rq.handle;
        in_ch.move_length = rq.len;
        cur_pin = pin;
        in_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    // Wait for the block to drain, then write the slot count
    task automatic write_slots(input logic [12:0] value);
        while (outcome_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        tbl_slots_reg = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic add_row(input logic is_cfg, input logic [12:0] cfg, input logic [2:0] op,
                           input int key_sel, input logic [31:0] handle, input logic [7:0] len,
                           input logic chk, input logic [1:0] status, input logic [12:0] count);
        stim_row_t r;
        r.is_cfg = is_cfg;
        r.cfg = cfg;
        r.op = op;
        r.key_sel = key_sel;
        r.handle = handle;
        r.len = len;
        r.chk = chk;
        r.status = status;
        r.count = count;
        stim_rows.push_back(r);
    endtask

    initial
    begin
        request_t    rq;
        pinned_t     pin;
        logic [12:0] phase_slots [9];
        int          pick;
        int          per_phase;

        errors = 0;
        cycles = 0;
        n_results = 0;
        for (int s = 0; s < 4; s++)
            n_status[s] = 0;
        idle_in = 0;
        idle_out = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_LOOKUP;
        in_ch.key_face_0 = '0;
        in_ch.key_face_1 = '0;
        in_ch.key_face_2 = '0;
        in_ch.key_face_3 = '0;
        in_ch.key_face_4 = '0;
        in_ch.key_face_5 = '0;
        in_ch.value_handle = '0;
        in_ch.move_length = '0;
        out_ch.ready = 1'b1;
        cur_pin = '0;

        tbl_slots_reg = 13'd4096;
        tbl_count = '0;
        for (int s = 0; s < TABLE_DEPTH; s++)
            tbl_valid[s] = 1'b0;
        for (int k = 0; k < POOL_KEYS; k++)
            for (int i = 0; i < KEY_WORDS; i++)
                key_pool[k][i] = (k == 12) ? 64'd0 : (k == 13) ? '1 : {$urandom, $urandom};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: fresh table at the reset slot count, then a one-slot table
        add_row(0, 0, OP_LOOKUP,    0, 32'h1,        8'd10,  1, ST_NOT_FOUND,   0);
        add_row(0, 0, OP_OVERWRITE, 0, 32'h1111,     8'd10,  1, ST_DONE,        1);
        add_row(0, 0, OP_LOOKUP,    0, 32'h0,        8'd0,   0, ST_DONE,        0);
        add_row(0, 0, OP_SHORTER,   0, 32'h2222,     8'd20,  1, ST_NOT_APPLIED, 1);
        add_row(0, 0, OP_SHORTER,   0, 32'h3333,     8'd10,  1, ST_NOT_APPLIED, 1);
        add_row(0, 0, OP_SHORTER,   0, 32'h4444,     8'd3,   1, ST_DONE,        1);
        add_row(0, 0, OP_IF_NEW,    0, 32'h5555,     8'd1,   1, ST_NOT_APPLIED, 1);
        add_row(0, 0, OP_IF_NEW,    1, 32'h6666,     8'd7,   1, ST_DONE,        2);
        add_row(0, 0, OP_OVERWRITE, 0, 32'h7777,     8'd9,   1, ST_DONE,        2);
        add_row(0, 0, OP_LOOKUP,    0, 32'h0,        8'd0,   0, ST_DONE,        0);
        add_row(0, 0, 3'd5,         2, 32'h0,        8'd0,   1, ST_NOT_APPLIED, 2);
        add_row(0, 0, 3'd7,         13, '1,          '1,     1, ST_NOT_APPLIED, 2);
        add_row(0, 0, OP_OVERWRITE, 12, 32'h0,       8'd0,   1, ST_DONE,        3);
        add_row(0, 0, OP_OVERWRITE, 13, '1,          '1,     1, ST_DONE,        4);
        add_row(0, 0, OP_LOOKUP,    13, 32'h0,       8'd0,   0, ST_DONE,        0);
        add_row(0, 0, OP_CLEAR,     0, 32'h0,        8'd0,   1, ST_DONE,        0);
        add_row(0, 0, OP_LOOKUP,    13, 32'h0,       8'd0,   1, ST_NOT_FOUND,   0);
        add_row(1, 13'd1, OP_LOOKUP, 0, 0, 0, 0, ST_DONE, 0);
        add_row(0, 0, OP_OVERWRITE, 0, 32'hA5A5A5A5, 8'd40,  1, ST_DONE,        1);
        add_row(0, 0, OP_OVERWRITE, 1, 32'h5A5A5A5A, 8'd41,  1, ST_FULL,        1);
        add_row(0, 0, OP_LOOKUP,    1, 32'h0,        8'd0,   1, ST_NOT_FOUND,   1);
        add_row(0, 0, OP_LOOKUP,    0, 32'h0,        8'd0,   0, ST_DONE,        0);
        // Register value 0 acts as one slot
        add_row(1, 13'd0, OP_LOOKUP, 0, 0, 0, 0, ST_DONE, 0);
        add_row(0, 0, OP_IF_NEW,    2, 32'h9,        8'd2,   1, ST_FULL,        1);
        add_row(0, 0, OP_CLEAR,     0, 32'h0,        8'd0,   1, ST_DONE,        0);

        foreach (stim_rows[r])
        begin
            if (stim_rows[r].is_cfg)
                write_slots(stim_rows[r].cfg);
            else
            begin
                rq.op = stim_rows[r].op;
                for (int i = 0; i < KEY_WORDS; i++)
                    rq.key[i] = key_pool[stim_rows[r].key_sel][i];
                rq.handle = stim_rows[r].handle;
                rq.len = stim_rows[r].len;
                pin.chk = stim_rows[r].chk;
                pin.status = stim_rows[r].status;
                pin.count = stim_rows[r].count;
                send_item(rq, pin);
            end
        end

        // Random part: nine phases, three idling mixes, slot counts including extremes
        phase_slots = '{13'd4096, 13'd1, 13'd8191, 13'd5, 13'd0, 13'd16, 13'd3, 13'd64, 13'd4096};
        per_phase = 61;
        pin = '0;
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph < 3)
            begin
                idle_in = 27;
                idle_out = 52;
            end
            else if (ph < 6)
            begin
                idle_in = 52;
                idle_out = 27;
            end
            else
            begin
                idle_in = 0;
                idle_out = 0;
            end
            write_slots(phase_slots[ph]);
            for (int n = 0; n < per_phase; n++)
            begin
                pick = $urandom_range(199);
                rq.op = (pick < 2) ? OP_CLEAR :
                        (pick < 6) ? 3'($urandom_range(7, 5)) :
                        (pick < 70) ? OP_LOOKUP : 3'($urandom_range(2));
                // Mostly keys from a small pool, so that matches and collisions happen
                if ($urandom_range(99) < 80)
                begin
                    pick = $urandom_range(POOL_KEYS - 1);
                    for (int i = 0; i < KEY_WORDS; i++)
                        rq.key[i] = key_pool[pick][i];
                end
                else
                    for (int i = 0; i < KEY_WORDS; i++)
                        rq.key[i] = {$urandom, $urandom};
                rq.handle = $urandom;
                rq.len = 8'($urandom_range(255));
                send_item(rq, pin);
            end
        end

        // Drain, then give the block time to show any stray result
        while (outcome_q.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        $display("Covered %0d results: done %0d, not applied %0d, full %0d, not found %0d",
                 n_results, n_status[ST_DONE], n_status[ST_NOT_APPLIED], n_status[ST_FULL],
                 n_status[ST_NOT_FOUND]);
        $display("Slot counts from one to the full depth, out-of-range writes and clears");
        if (errors == 0 && outcome_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
